### sv/caldc_pkg.sv
// Shared types, constants and calendar helper functions for the date completion pipeline.
// Used by every module of the block; depends on nothing.

package caldc_pkg;

    // Years are carried as year minus 1900. A bias of 21 full 400-year cycles
    // keeps every biased year positive before the reduction modulo 400.
    localparam int YEAR_BASE   = 1900;
    localparam int CYCLE_YEARS = 400;
    localparam int YEAR_BIAS   = YEAR_BASE + 21 * CYCLE_YEARS;
    localparam int BIAS_W      = 15;

    // floor(v / 400) = (v * DIV_MUL) >> DIV_SHIFT, exact for v below 43690.
    localparam int DIV_MUL   = 20972;
    localparam int DIV_SHIFT = 23;
    localparam int QUOT_W    = 6;

    // Bit positions of the presence mask.
    localparam int KB_YEAR = 0;
    localparam int KB_MON  = 1;
    localparam int KB_YDAY = 2;
    localparam int KB_MDAY = 3;
    localparam int KB_WDAY = 4;

    localparam logic [4:0] MASK_ALL    = 5'b11111;
    localparam logic [2:0] WDAY_SUNDAY = 3'd0;
    localparam logic [2:0] WDAY_WRAP   = 3'd7;
    localparam logic [3:0] MONTH_LAST  = 4'd11;
    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [8:0] YMOD_LAST   = 9'd399;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [3:0]         midx;
        logic [4:0]         mday;
        logic [8:0]         yday;
        logic [2:0]         wday;
        logic [4:0]         mask;
        logic               week_given;
        logic               start_monday;
        logic [5:0]         week;
    } caldc_item_t;

    typedef struct packed {
        logic       leap;
        logic [2:0] jan1;
    } caldc_attr_t;

    typedef struct packed {
        caldc_item_t item;
        logic [8:0]  ymod;
    } caldc_s2_t;

    typedef struct packed {
        caldc_item_t item;
        caldc_attr_t cur;
        caldc_attr_t nxt;
    } caldc_s3_t;

    typedef struct packed {
        caldc_item_t item;
        logic        invalid;
        caldc_attr_t cur;
        caldc_attr_t nxt;
    } caldc_s4_t;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         mday;
        logic [8:0]         yday;
        logic [2:0]         wday;
        logic [4:0]         mask;
        logic               invalid;
    } caldc_result_t;

    // First ordinal day of a month; index 12 gives the year's length.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        return base + {8'd0, leap && (idx >= 4'd2)};
    endfunction

    // Remainder modulo 7 by summing octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [9:0] x);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
        t = 4'(s[2:0]) + 4'(s[4:3]);
        u = t[2:0] + 3'(t[3]);
        return (u == 3'd7) ? 3'd0 : u;
    endfunction

    // Leap flag and weekday of January 1 from the year modulo 400.
    function automatic caldc_attr_t year_attr(input logic [8:0] ymod);
        logic [1:0]  cent;
        logic [6:0]  rest;
        logic [9:0]  sum;
        caldc_attr_t a;
        priority if (ymod >= 9'd300)
        begin
            cent = 2'd3;
            rest = 7'(ymod - 9'd300);
        end
        else if (ymod >= 9'd200)
        begin
            cent = 2'd2;
            rest = 7'(ymod - 9'd200);
        end
        else if (ymod >= 9'd100)
        begin
            cent = 2'd1;
            rest = 7'(ymod - 9'd100);
        end
        else
        begin
            cent = 2'd0;
            rest = 7'(ymod);
        end
        a.leap = (rest[1:0] == 2'd0) && ((rest != 7'd0) || (cent == 2'd0));
        sum = 10'({~cent, 1'b0}) + 10'(rest) + 10'(rest[6:2])
            + (a.leap ? 10'd6 : 10'd0) + 10'd1;
        a.jan1 = mod7(sum);
        return a;
    endfunction

endpackage

### sv/calendar_date_completion.sv
// Top level of the Gregorian date completion pipeline.
// Instantiates caldc_mod400, caldc_attr, caldc_ordinal and caldc_complete; uses caldc_pkg.
//
// Usage: each word on the slave stream carries a partly known date (year minus 1900,
// month, day of month, day of year, weekday) with presence bits in tuser, and
// optionally a week number. The block fills in what can be derived and returns
// exactly one word on the master stream for every word it accepts, in order.
// Words are accepted on a rising edge where tvalid and tready are both high.
// The datapath is five register stages: year modulo 400 by reciprocal multiply,
// the remainder, year attributes (leap flag, weekday of January 1), the ordinal
// day, and finally month, day of month and weekday in the output register.
// An accepted word moves through these stages in order, held by any stall, before it is offered.
// One word can enter in every cycle; throughput is one word per clock while m_axis_tready is high.
// Each stage takes a new word whenever it is empty or its successor moves, so a
// stalled receiver fills the pipeline; s_axis_tready drops only once all five
// stages hold words. Nothing is dropped or repeated under stalls.
// Reset clears every stage's valid bit; the data registers are not reset.

module calendar_date_completion import caldc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] year_since_1900, [17:14] month, [22:18] day_of_month,
    // [31:23] day_of_year, [34:32] weekday, [40:35] week_number, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    // [4:0] known_mask, [5] week_given, [6] week_starts_monday
    input  logic [6:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_of_month_out,
    // [31:23] day_of_year_out, [34:32] weekday_out, [39:35] zero
    output logic [39:0] m_axis_tdata,
    // [4:0] known_mask_out, [5] date_invalid
    output logic [5:0]  m_axis_tuser
);

    caldc_item_t   in_item;
    caldc_s2_t     s2_data;
    caldc_s3_t     s3_data;
    caldc_s4_t     s4_data;
    caldc_result_t result;
    logic          s2_valid;
    logic          s2_ready;
    logic          s3_valid;
    logic          s3_ready;
    logic          s4_valid;
    logic          s4_ready;

    // Unpack the slave word. The month index is filled in by the first stage.
    always_comb
    begin
        in_item.year         = $signed(s_axis_tdata[13:0]);
        in_item.month        = s_axis_tdata[17:14];
        in_item.midx         = s_axis_tdata[17:14];
        in_item.mday         = s_axis_tdata[22:18];
        in_item.yday         = s_axis_tdata[31:23];
        in_item.wday         = s_axis_tdata[34:32];
        in_item.week         = s_axis_tdata[40:35];
        in_item.mask         = s_axis_tuser[4:0];
        in_item.week_given   = s_axis_tuser[5];
        in_item.start_monday = s_axis_tuser[6];
    end

    caldc_mod400 u_mod400
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_axis_tvalid),
        .up_ready (s_axis_tready),
        .up_data  (in_item),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    caldc_attr u_attr
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    caldc_ordinal u_ordinal
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up_data  (s3_data),
        .dn_valid (s4_valid),
        .dn_ready (s4_ready),
        .dn_data  (s4_data)
    );

    caldc_complete u_complete
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s4_valid),
        .up_ready (s4_ready),
        .up_data  (s4_data),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_data  (result)
    );

    // Pack the master word.
    assign m_axis_tdata = {5'd0, result.wday, result.yday, result.mday, result.month,
                           result.year};
    assign m_axis_tuser = {result.invalid, result.mask};

    // The input side can only be held off by a full pipeline behind a stalled receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // A failed derivation means the year was known and the day of year was not.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[5]) |->
            (m_axis_tuser[KB_YEAR] && !m_axis_tuser[KB_YDAY]))
        else $error("invalid date with inconsistent presence bits");

    // Once year and day of year are known, every field must have been completed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[5] && m_axis_tuser[KB_YEAR] && m_axis_tuser[KB_YDAY])
            |-> (m_axis_tuser[4:0] == MASK_ALL))
        else $error("completed date missing fields");

    // The weekday code for Sunday is always folded to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:32] != WDAY_WRAP))
        else $error("weekday code seven on output");

endmodule

### sv/caldc_mod400.sv
// First two pipeline stages: reduce the full year modulo 400.
// Stage one multiplies by a reciprocal, stage two subtracts; depends on caldc_pkg.

module caldc_mod400 import caldc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  caldc_item_t up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output caldc_s2_t   dn_data
);

    logic              s1_valid_reg;
    caldc_item_t       s1_item_reg;
    logic [BIAS_W-1:0] s1_bias_reg;
    logic [QUOT_W-1:0] s1_quot_reg;
    logic              s2_valid_reg;
    caldc_s2_t         s2_reg;

    caldc_item_t       s1_item_next;
    logic [15:0]       bias_sum;
    logic [BIAS_W-1:0] s1_bias_next;
    logic [29:0]       product;
    logic [QUOT_W-1:0] s1_quot_next;
    logic [BIAS_W-1:0] quot_times;
    logic [BIAS_W-1:0] rem_full;
    caldc_s2_t         s2_next;
    logic              s1_ready;
    logic              s2_ready;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // A weekday code of 7 means Sunday; a month past December indexes December.
    always_comb
    begin
        s1_item_next = up_data;
        if (up_data.wday == WDAY_WRAP)
            s1_item_next.wday = WDAY_SUNDAY;
        s1_item_next.midx = (up_data.month > MONTH_LAST) ? MONTH_LAST : up_data.month;
        bias_sum     = {{2{up_data.year[13]}}, up_data.year} + 16'(YEAR_BIAS);
        s1_bias_next = bias_sum[BIAS_W-1:0];
        product      = 30'(s1_bias_next) * 30'(DIV_MUL);
        s1_quot_next = product[DIV_SHIFT +: QUOT_W];
    end

    always_comb
    begin
        quot_times   = BIAS_W'(s1_quot_reg) * BIAS_W'(CYCLE_YEARS);
        rem_full     = s1_bias_reg - quot_times;
        s2_next.item = s1_item_reg;
        s2_next.ymod = rem_full[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= up_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_item_reg <= s1_item_next;
            s1_bias_reg <= s1_bias_next;
            s1_quot_reg <= s1_quot_next;
        end
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

endmodule

### sv/caldc_attr.sv
// Third pipeline stage: leap flag and weekday of January 1 for the year and the next year.
// Depends on caldc_pkg.

module caldc_attr import caldc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  caldc_s2_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output caldc_s3_t dn_data
);

    logic       valid_reg;
    caldc_s3_t  data_reg;
    caldc_s3_t  data_next;
    logic [8:0] ymod_nxt;

    assign up_ready = !valid_reg || dn_ready;

    // The next year is needed when the ordinal day rolls past the year's end.
    always_comb
    begin
        ymod_nxt       = (up_data.ymod == YMOD_LAST) ? 9'd0 : up_data.ymod + 9'd1;
        data_next.item = up_data.item;
        data_next.cur  = year_attr(up_data.ymod);
        data_next.nxt  = year_attr(ymod_nxt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### sv/caldc_ordinal.sv
// Fourth pipeline stage: derive a missing day of year from month and day or from the week.
// Depends on caldc_pkg.

module caldc_ordinal import caldc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  caldc_s3_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output caldc_s4_t dn_data
);

    logic        valid_reg;
    caldc_s4_t   data_reg;
    caldc_s4_t   data_next;
    caldc_item_t it;
    logic [10:0] nd_md;
    logic [10:0] nd_wk;
    logic [3:0]  off_raw;
    logic [3:0]  off;
    logic [2:0]  wd;
    logic [10:0] week7;

    assign up_ready = !valid_reg || dn_ready;

    // Both candidate ordinals are 11 bits wide; bit 10 set means negative.
    always_comb
    begin
        it      = up_data.item;
        nd_md   = 11'(month_start(up_data.cur.leap, it.midx)) + 11'(it.mday) - 11'd1;
        wd      = it.mask[KB_WDAY] ? it.wday : 3'(it.start_monday);
        off_raw = 4'd7 - 4'(up_data.cur.jan1) + 4'(it.start_monday);
        off     = (off_raw >= 4'd7) ? off_raw - 4'd7 : off_raw;
        week7   = 11'({it.week, 3'b000}) - 11'(it.week);
        nd_wk   = 11'(off) + week7 + 11'(wd) - 11'd7 - 11'(it.start_monday);

        data_next.cur     = up_data.cur;
        data_next.nxt     = up_data.nxt;
        data_next.invalid = 1'b0;
        data_next.item    = it;
        if (!it.mask[KB_YDAY] && it.mask[KB_YEAR])
        begin
            if (it.mask[KB_MON] && it.mask[KB_MDAY])
            begin
                if (nd_md[10])
                    data_next.invalid = 1'b1;
                else
                begin
                    data_next.item.yday          = nd_md[8:0];
                    data_next.item.mask[KB_YDAY] = 1'b1;
                end
            end
            else if (it.week_given)
            begin
                if (nd_wk[10])
                    data_next.invalid = 1'b1;
                else
                begin
                    data_next.item.yday          = nd_wk[8:0];
                    data_next.item.mask[KB_YDAY] = 1'b1;
                    if (!it.mask[KB_WDAY])
                    begin
                        data_next.item.wday          = 3'(it.start_monday);
                        data_next.item.mask[KB_WDAY] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### sv/caldc_complete.sv
// Fifth pipeline stage and output register: rollover, month search, day of month, weekday.
// Depends on caldc_pkg.

module caldc_complete import caldc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    output logic          up_ready,
    input  caldc_s4_t     up_data,
    output logic          dn_valid,
    input  logic          dn_ready,
    output caldc_result_t dn_data
);

    logic          valid_reg;
    caldc_result_t data_reg;
    caldc_result_t data_next;
    caldc_item_t   it;
    logic          active;
    logic          roll;
    logic [8:0]    year_len;
    logic [8:0]    yday2;
    caldc_attr_t   at;
    logic [3:0]    month_cnt;
    logic [3:0]    midx2;
    logic [8:0]    mday_full;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        it       = up_data.item;
        active   = !up_data.invalid && it.mask[KB_YDAY] && it.mask[KB_YEAR];
        year_len = up_data.cur.leap ? DAYS_LEAP : DAYS_COMMON;
        roll     = active && !it.mask[KB_MON] && (it.yday >= year_len);
        yday2    = roll ? it.yday - year_len : it.yday;
        at       = roll ? up_data.nxt : up_data.cur;

        // The month is the number of later month starts already reached.
        month_cnt = 4'd0;
        for (int k = 1; k <= 11; k++)
        begin
            if (yday2 >= month_start(at.leap, 4'(k)))
                month_cnt = month_cnt + 4'd1;
        end
        midx2     = it.mask[KB_MON] ? it.midx : month_cnt;
        mday_full = yday2 - month_start(at.leap, midx2) + 9'd1;

        data_next.year    = roll ? it.year + 14'sd1 : it.year;
        data_next.month   = (active && !it.mask[KB_MON]) ? month_cnt : it.month;
        data_next.mday    = (active && !it.mask[KB_MDAY]) ? mday_full[4:0] : it.mday;
        data_next.yday    = yday2;
        data_next.wday    = (active && !it.mask[KB_WDAY])
                          ? mod7(10'(at.jan1) + 10'(yday2)) : it.wday;
        data_next.mask    = active ? MASK_ALL : it.mask;
        data_next.invalid = up_data.invalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
